// ===== rtl/wdb_pkg.sv =====
`default_nettype none

package wdb_pkg;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_WINDOW_RADIUS = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_index_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  localparam logic [10:0] RESET_WIDTH  = 11'd640;
  localparam logic [12:0] RESET_HEIGHT = 13'd480;
  localparam logic [2:0]  RESET_RADIUS = 3'd0;
  localparam int unsigned MAX_BURST    = 8;

  typedef struct packed {
    logic       action;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  dark;
    logic [7:0]  bright;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        burst_last;
    logic        frame_last;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/window_dark_bright_channel.sv =====
`default_nettype none

// channel | handshake             | word
// in      | in_valid_i/in_stall_o  | wdb_pkg::in_word_t (action, blue, green, red)
// out     | out_valid_o/out_stall_i| wdb_pkg::out_word_t (dark, bright, row, col, lasts)
// cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One input word at a time. Each released result passes through SETUP, SCAN, DRAIN
// and EMIT: the window of up to (2R+1)^2 entries is scanned one line store entry
// per cycle through the single read port.
// Output is held until taken; input stalls while a burst is being produced or a cfg write is offered.
// Reset clears positions and loads register defaults; line store starts undefined.

module window_dark_bright_channel #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wdb_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output wdb_pkg::out_word_t   out_word_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wdb_pkg::cfg_index_e  cfg_index_i,
  input  wire [12:0]           cfg_data_i
);
  import wdb_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RL    = 2 * MAX_RADIUS + 1;
  localparam int unsigned LW    = $clog2(RL + 1);
  localparam int unsigned DEPTH = RL * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned X     = WW + 1;
  localparam int unsigned RX    = HW + 1;
  localparam int unsigned TW    = LW + 5;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  state_e        state_q, state_d;
  logic [10:0]   cfg_w_q, cfg_w_d;
  logic [12:0]   cfg_h_q, cfg_h_d;
  logic [2:0]    cfg_r_q, cfg_r_d;
  logic [RW-1:0] in_row_q, in_row_d, pend_row_q, pend_row_d;
  logic [CW-1:0] in_col_q, in_col_d, pend_col_q, pend_col_d;
  logic [LW-1:0] in_line_q, in_line_d, pend_line_q, pend_line_d, ln_q, ln_d;
  logic          draining_q, draining_d, fe_q, fe_d, rd_vld_q, rd_vld_d;
  logic [X-1:0]  cnt_q, cnt_d;
  logic [3:0]    nemit_q, nemit_d, k_q, k_d;
  logic [CW-1:0] c0_q, c0_d, c1_q, c1_d, cc_q, cc_d;
  logic [4:0]    rrem_q, rrem_d;
  logic [7:0]    mn_q, mn_d, mx_q, mx_d;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [3:0]    rad;
  logic          in_acc, out_acc, cfg_acc, wr_en;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;

  assign w_eff = (cfg_w_q == '0) ? WW'(1) :
                 (32'(cfg_w_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_w_q);
  assign h_eff = (cfg_h_q == '0) ? HW'(1) :
                 (32'(cfg_h_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_h_q);
  assign rad   = (32'(cfg_r_q) > MAX_RADIUS) ? 4'(MAX_RADIUS) : 4'(cfg_r_q);

  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  assign raddr = AW'(ln_q) * AW'(MAX_WIDTH) + AW'(cc_q);
  assign waddr = AW'(in_line_q) * AW'(MAX_WIDTH) + AW'(in_col_q);

  assign out_word_o.dark       = mn_q;
  assign out_word_o.bright     = mx_q;
  assign out_word_o.out_row    = 12'(pend_row_q);
  assign out_word_o.out_col    = 10'(pend_col_q);
  assign out_word_o.burst_last = (X'(k_q) + X'(1)) == cnt_q;
  assign out_word_o.frame_last = (HW'(pend_row_q) == h_eff - HW'(1)) &&
                                 (WW'(pend_col_q) == w_eff - WW'(1));

  always_comb begin
    logic [RW-1:0] pr_e;
    logic [CW-1:0] pc_e;
    logic [LW-1:0] pl_e;
    logic [7:0]    pmn, pmx;
    logic [RX-1:0] target;
    logic [X-1:0]  cnt;
    logic          fe, last;
    logic [3:0]    dup, ddn;
    logic [HW-1:0] hrem;
    logic [TW-1:0] lst;

    state_d     = state_q;
    cfg_w_d     = cfg_w_q;
    cfg_h_d     = cfg_h_q;
    cfg_r_d     = cfg_r_q;
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    in_line_d   = in_line_q;
    pend_row_d  = pend_row_q;
    pend_col_d  = pend_col_q;
    pend_line_d = pend_line_q;
    draining_d  = draining_q;
    fe_d        = fe_q;
    cnt_d       = cnt_q;
    nemit_d     = nemit_q;
    k_d         = k_q;
    c0_d        = c0_q;
    c1_d        = c1_q;
    cc_d        = cc_q;
    ln_d        = ln_q;
    rrem_d      = rrem_q;
    mn_d        = mn_q;
    mx_d        = mx_q;
    rd_vld_d    = (state_q == ST_SCAN);
    wr_en       = 1'b0;
    pr_e        = draining_q ? '0 : pend_row_q;
    pc_e        = draining_q ? '0 : pend_col_q;
    pl_e        = draining_q ? '0 : pend_line_q;
    pmn         = in_word_i.blue;
    pmx         = in_word_i.blue;
    if (in_word_i.green < pmn) pmn = in_word_i.green;
    if (in_word_i.red < pmn) pmn = in_word_i.red;
    if (in_word_i.green > pmx) pmx = in_word_i.green;
    if (in_word_i.red > pmx) pmx = in_word_i.red;
    wdata       = {pmn, pmx};
    target      = RX'(in_row_q) - RX'(rad);
    cnt         = '0;
    if ((RX'(in_row_q) >= RX'(rad)) && (RX'(pr_e) == target)) begin
      if (X'(in_col_q) == X'(w_eff) - X'(1)) begin
        cnt = X'(w_eff) - X'(pc_e);
      end else if ((X'(in_col_q) >= X'(rad)) && (X'(pc_e) + X'(rad) <= X'(in_col_q))) begin
        cnt = X'(in_col_q) - X'(rad) - X'(pc_e) + X'(1);
      end
    end
    fe   = (WW'(in_col_q) + WW'(1) >= w_eff) && (HW'(in_row_q) + HW'(1) >= h_eff);
    last = (k_q + 4'd1) == nemit_q;

    dup  = (HW'(pend_row_q) >= HW'(rad)) ? rad : 4'(pend_row_q);
    hrem = h_eff - HW'(1) - HW'(pend_row_q);
    ddn  = (hrem < HW'(rad)) ? 4'(hrem) : rad;
    lst  = (TW'(pend_line_q) >= TW'(dup)) ? TW'(pend_line_q) - TW'(dup)
                                          : TW'(pend_line_q) + TW'(RL) - TW'(dup);

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          unique case (cfg_index_i)
            CFG_IMAGE_WIDTH:   cfg_w_d = cfg_data_i[10:0];
            CFG_IMAGE_HEIGHT:  cfg_h_d = cfg_data_i;
            CFG_WINDOW_RADIUS: cfg_r_d = cfg_data_i[2:0];
            default: ;
          endcase
          if (cfg_index_i != CFG_UNUSED) begin
            in_row_d    = '0;
            in_col_d    = '0;
            in_line_d   = '0;
            pend_row_d  = '0;
            pend_col_d  = '0;
            pend_line_d = '0;
            draining_d  = 1'b0;
          end
        end else if (in_acc && in_word_i.action == ACT_FLUSH) begin
          if (draining_q) begin
            cnt_d   = X'(1);
            nemit_d = 4'd1;
            k_d     = '0;
            fe_d    = 1'b0;
            state_d = ST_SETUP;
          end
        end else if (in_acc) begin
          wr_en       = 1'b1;
          pend_row_d  = pr_e;
          pend_col_d  = pc_e;
          pend_line_d = pl_e;
          draining_d  = 1'b0;
          cnt_d       = cnt;
          nemit_d     = (cnt > X'(MAX_BURST)) ? 4'(MAX_BURST) : 4'(cnt);
          k_d         = '0;
          fe_d        = fe;
          if (cnt == '0) begin
            if (fe) draining_d = (pr_e != '0) || (pc_e != '0);
          end else begin
            state_d = ST_SETUP;
          end
          if (WW'(in_col_q) + WW'(1) >= w_eff) begin
            in_col_d = '0;
            if (HW'(in_row_q) + HW'(1) >= h_eff) begin
              in_row_d  = '0;
              in_line_d = '0;
            end else begin
              in_row_d  = in_row_q + RW'(1);
              in_line_d = (32'(in_line_q) == RL - 1) ? '0 : in_line_q + LW'(1);
            end
          end else begin
            in_col_d = in_col_q + CW'(1);
          end
        end
      end
      ST_SETUP: begin
        c0_d    = (X'(pend_col_q) >= X'(rad)) ? pend_col_q - CW'(rad) : '0;
        c1_d    = (X'(pend_col_q) + X'(rad) >= X'(w_eff)) ? CW'(w_eff - WW'(1))
                                                         : CW'(X'(pend_col_q) + X'(rad));
        cc_d    = (X'(pend_col_q) >= X'(rad)) ? pend_col_q - CW'(rad) : '0;
        rrem_d  = 5'(dup) + 5'(ddn);
        ln_d    = LW'(lst);
        mn_d    = 8'hff;
        mx_d    = 8'h00;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cc_q == c1_q) begin
          cc_d = c0_q;
          ln_d = (32'(ln_q) == RL - 1) ? '0 : ln_q + LW'(1);
          if (rrem_q == '0) state_d = ST_DRAIN;
          else rrem_d = rrem_q - 5'd1;
        end else begin
          cc_d = cc_q + CW'(1);
        end
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_acc) begin
          if (WW'(pend_col_q) + WW'(1) >= w_eff) begin
            pend_col_d = '0;
            if (HW'(pend_row_q) + HW'(1) >= h_eff) begin
              pend_row_d  = '0;
              pend_line_d = '0;
              draining_d  = 1'b0;
            end else begin
              pend_row_d  = pend_row_q + RW'(1);
              pend_line_d = (32'(pend_line_q) == RL - 1) ? '0 : pend_line_q + LW'(1);
            end
          end else begin
            pend_col_d = pend_col_q + CW'(1);
          end
          if (last) begin
            state_d = ST_IDLE;
            if (fe_q) draining_d = (pend_row_d != '0) || (pend_col_d != '0);
          end else begin
            k_d     = k_q + 4'd1;
            state_d = ST_SETUP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (rd_vld_q) begin
      if (rdata_q[15:8] < mn_q) mn_d = rdata_q[15:8];
      if (rdata_q[7:0] > mx_q) mx_d = rdata_q[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_w_q     <= RESET_WIDTH;
      cfg_h_q     <= RESET_HEIGHT;
      cfg_r_q     <= RESET_RADIUS;
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_line_q   <= '0;
      pend_row_q  <= '0;
      pend_col_q  <= '0;
      pend_line_q <= '0;
      draining_q  <= 1'b0;
      fe_q        <= 1'b0;
      rd_vld_q    <= 1'b0;
      cnt_q       <= '0;
      nemit_q     <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      cfg_w_q     <= cfg_w_d;
      cfg_h_q     <= cfg_h_d;
      cfg_r_q     <= cfg_r_d;
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      in_line_q   <= in_line_d;
      pend_row_q  <= pend_row_d;
      pend_col_q  <= pend_col_d;
      pend_line_q <= pend_line_d;
      draining_q  <= draining_d;
      fe_q        <= fe_d;
      rd_vld_q    <= rd_vld_d;
      cnt_q       <= cnt_d;
      nemit_q     <= nemit_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c0_q   <= c0_d;
    c1_q   <= c1_d;
    cc_q   <= cc_d;
    ln_q   <= ln_d;
    rrem_q <= rrem_d;
    mn_q   <= mn_d;
    mx_q   <= mx_d;
  end

`ifndef SYNTHESIS
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_scan_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> rd_vld_q) else $error("scan read not tracked");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !out_valid_o) else $error("config open during burst");
  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (k_q < nemit_q)) else $error("burst index overrun");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
  import wdb_pkg::*;

  localparam int RING_LINES = 15;
  localparam int LINE_LEN = 1024;
  localparam int SETTLE = 2200;
  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_index_e cfg_index = CFG_IMAGE_WIDTH;
  logic [12:0] cfg_data = '0;

  window_dark_bright_channel dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_word_t pixel_queue[$];
  out_word_t window_expect[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;

  // predictor state
  logic [15:0] ring [0:RING_LINES*LINE_LEN-1];
  logic [10:0] reg_width = RESET_WIDTH;
  logic [12:0] reg_height = RESET_HEIGHT;
  logic [2:0] reg_radius = RESET_RADIUS;
  int unsigned row_in = 0, col_in = 0, row_pend = 0, col_pend = 0;
  bit draining = 0;

  function automatic int unsigned eff_width();
    if (reg_width == 0) return 1;
    return (reg_width > LINE_LEN) ? LINE_LEN : reg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (reg_height == 0) return 1;
    return (reg_height > 4096) ? 4096 : reg_height;
  endfunction

  task automatic restart_stream();
    row_in = 0; col_in = 0; row_pend = 0; col_pend = 0; draining = 0;
  endtask

  task automatic enqueue(in_word_t p);
    pixel_queue = {pixel_queue, p};
  endtask

  task automatic release_window(bit last);
    int unsigned w, h, rad, r0, r1, c0, c1, mn, mx, r, c;
    logic [15:0] e;
    out_word_t o;
    w = eff_width(); h = eff_height(); rad = reg_radius;
    r0 = (row_pend >= rad) ? row_pend - rad : 0;
    r1 = (row_pend + rad >= h) ? h - 1 : row_pend + rad;
    c0 = (col_pend >= rad) ? col_pend - rad : 0;
    c1 = (col_pend + rad >= w) ? w - 1 : col_pend + rad;
    mn = 255; mx = 0;
    for (r = r0; r <= r1; r++)
      for (c = c0; c <= c1; c++) begin
        e = ring[(r % RING_LINES) * LINE_LEN + c];
        if (e[15:8] < mn) mn = e[15:8];
        if (e[7:0] > mx) mx = e[7:0];
      end
    o.dark = mn[7:0];
    o.bright = mx[7:0];
    o.out_row = row_pend[11:0];
    o.out_col = col_pend[9:0];
    o.burst_last = last;
    o.frame_last = (row_pend == h - 1 && col_pend == w - 1);
    window_expect = {window_expect, o};
    col_pend++;
    if (col_pend >= w) begin
      col_pend = 0;
      row_pend++;
      if (row_pend >= h) begin
        row_pend = 0;
        draining = 0;
      end
    end
  endtask

  task automatic predict_word(in_word_t wd);
    int unsigned w, h, rad, mn, mx, cnt, i;
    w = eff_width(); h = eff_height(); rad = reg_radius;
    if (wd.action == ACT_FLUSH) begin
      if (draining) release_window(1'b1);
      return;
    end
    if (draining) begin
      row_pend = 0; col_pend = 0; draining = 0;
    end
    mn = wd.blue; mx = wd.blue;
    if (wd.green < mn) mn = wd.green;
    if (wd.red < mn) mn = wd.red;
    if (wd.green > mx) mx = wd.green;
    if (wd.red > mx) mx = wd.red;
    ring[(row_in % RING_LINES) * LINE_LEN + col_in] = {mn[7:0], mx[7:0]};
    if (row_in >= rad && row_pend == row_in - rad) begin
      cnt = 0;
      if (col_in == w - 1) cnt = w - col_pend;
      else if (col_in >= rad && col_pend + rad <= col_in) cnt = col_in - rad - col_pend + 1;
      for (i = 0; i < cnt && i < MAX_BURST; i++) release_window(i + 1 == cnt);
    end
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
      if (row_in >= h) begin
        row_in = 0;
        if (row_pend != 0 || col_pend != 0) draining = 1;
      end
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_word(in_word);
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_word <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (window_expect.size() == 0) begin
          report("unexpected word row/col", out_word.out_row, out_word.out_col);
        end else begin
          want = window_expect.pop_front();
          if (out_word.dark != want.dark) report("dark", out_word.dark, want.dark);
          if (out_word.bright != want.bright) report("bright", out_word.bright, want.bright);
          if (out_word.out_row != want.out_row) report("row", out_word.out_row, want.out_row);
          if (out_word.out_col != want.out_col) report("col", out_word.out_col, want.out_col);
          if (out_word.burst_last != want.burst_last)
            report("burst_last", out_word.burst_last, want.burst_last);
          if (out_word.frame_last != want.frame_last)
            report("frame_last", out_word.frame_last, want.frame_last);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drain_all();
    while (pixel_queue.size() != 0 || in_valid || window_expect.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [12:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH: reg_width = val[10:0];
      CFG_IMAGE_HEIGHT: reg_height = val;
      CFG_WINDOW_RADIUS: reg_radius = val[2:0];
      default: return;
    endcase
    restart_stream();
  endtask

  task automatic set_geometry(int w, int h, int rad);
    drain_all();
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_IMAGE_WIDTH, 13'(w));
    write_reg(CFG_IMAGE_HEIGHT, 13'(h));
    write_reg(CFG_WINDOW_RADIUS, 13'(rad));
  endtask

  function automatic in_word_t pixel(int b, int g, int r);
    in_word_t p;
    p.action = ACT_PIXEL;
    p.blue = 8'(b); p.green = 8'(g); p.red = 8'(r);
    return p;
  endfunction

  function automatic in_word_t flush_word();
    in_word_t p;
    p.action = ACT_FLUSH;
    p.blue = 8'($urandom);
    p.green = 8'($urandom);
    p.red = 8'($urandom);
    return p;
  endfunction

  task automatic push_frame(int n, int flushes);
    for (int i = 0; i < n; i++)
      enqueue(pixel($urandom_range(255), $urandom_range(255), $urandom_range(255)));
    for (int i = 0; i < flushes; i++) enqueue(flush_word());
  endtask

  initial begin
    int w, h, rad, sent, kind, n, f;
    for (int i = 0; i < RING_LINES * LINE_LEN; i++) ring[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: small frame, extremes, flush before drain, pixel during drain
    set_geometry(3, 3, 1);
    enqueue(flush_word());
    enqueue(pixel(0, 255, 128));
    enqueue(pixel(255, 255, 255));
    enqueue(pixel(0, 0, 0));
    enqueue(pixel(170, 85, 255));
    enqueue(pixel(85, 170, 0));
    enqueue(pixel(1, 254, 127));
    push_frame(3, 2);
    enqueue(pixel(255, 0, 255));
    push_frame(8, 4);
    set_geometry(2047, 8191, 7);
    push_frame(12, 1);
    set_geometry(0, 0, 0);
    push_frame(3, 1);
    drain_all();
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_UNUSED, 13'($urandom));
    push_frame(2, 0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 27 : (phase == 1) ? 47 : 0;
      recv_idle = (phase == 0) ? 47 : (phase == 1) ? 27 : 0;
      sent = 0;
      while (sent < 150) begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 8);
        rad = $urandom_range(0, 7);
        set_geometry(w, h, rad);
        repeat ($urandom_range(1, 3)) begin
          kind = $urandom_range(9);
          if (kind < 7) begin
            n = w * h;
            f = rad * w + 1;
          end else if (kind < 9) begin
            n = $urandom_range(1, w * h);
            f = $urandom_range(0, 3);
          end else begin
            n = w * h;
            f = 1;
          end
          push_frame(n, f);
          if (kind == 9) drain_all();
          sent += n + f;
        end
      end
    end

    drain_all();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
